/* sv/ipc_pkg.sv */
// Shared types and constants for the iteration palette colorizer.
// Used by the top level and the remainder pipeline; depends on nothing.
package ipc_pkg;

  localparam int CountW  = 24;
  localparam int HueW    = 24;
  localparam int AddrInW = 12;
  localparam int ChanW   = 8;
  localparam int CfgW    = 32;
  localparam int CfgIdxW = 3;
  localparam int SumW    = 33;
  localparam int ProdW   = 50;
  localparam int ScaleSh = 8;
  localparam int QuoW    = 40;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [CfgIdxW-1:0] REG_ENTRIES = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SCALE   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PHASE   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OFFSET  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MIN     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MAX     = 3'd5;

  typedef struct packed {
    logic               op;
    logic [AddrInW-1:0] addr;
    logic [HueW-1:0]    hv;
    logic               black;
  } side_t;

endpackage

/* sv/ipc_ram.sv */
// Generic single-address RAM with registered read.
// Standalone; no package dependency.
module ipc_ram #(
  parameter int W = 24,
  parameter int D = 4096
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] addr,
  input  logic [W-1:0]         wdata,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* sv/ipc_mod_pipe.sv */
// Pipelined remainder unit: one dividend bit per stage, then a wrap stage
// that makes the remainder of a negative value non-negative. Uses ipc_pkg.
module ipc_mod_pipe #(
  parameter int DW = 40,
  parameter int NW = 13
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  ipc_pkg::side_t in_side,
  input  logic           in_neg,
  input  logic [DW-1:0]  in_mag,
  input  logic [NW-1:0]  n,
  output logic           out_valid,
  output ipc_pkg::side_t out_side,
  output logic [NW-1:0]  out_rem
);
  import ipc_pkg::*;

  function automatic logic [NW-1:0] rem_step(logic [NW-1:0] r, logic b, logic [NW-1:0] d);
    logic [NW:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[NW-1:0];
  endfunction

  logic [DW-1:0] vld;
  logic [DW-1:0] neg;
  side_t         side [DW];
  logic [DW-1:0] mag  [DW];
  logic [NW-1:0] rem  [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic          pv;
    logic          pn;
    side_t         ps;
    logic [DW-1:0] pm;
    logic [NW-1:0] pr;
    if (k == 0) begin : g_first
      assign pv = in_valid;
      assign pn = in_neg;
      assign ps = in_side;
      assign pm = in_mag;
      assign pr = '0;
    end else begin : g_rest
      assign pv = vld[k-1];
      assign pn = neg[k-1];
      assign ps = side[k-1];
      assign pm = mag[k-1];
      assign pr = rem[k-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= pv;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        neg[k]  <= pn;
        side[k] <= ps;
        mag[k]  <= pm;
        rem[k]  <= rem_step(pr, pm[DW-1-k], n);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= side[DW-1];
      if (neg[DW-1] && (rem[DW-1] != '0)) begin
        out_rem <= n - rem[DW-1];
      end else begin
        out_rem <= rem[DW-1];
      end
    end
  end

endmodule

/* sv/iteration_palette_colorizer_unit.sv */
// Iteration palette colorizer: palette loads and pixel coloring in one stream.
// The path from an accepted transaction to its pixel result runs through three front
// stages, the 40-stage one-bit-per-stage remainder pipeline with its wrap stage, and the
// palette RAM read, hue and output registers. One transaction is accepted every cycle; a
// result held by the sink stalls the whole pipeline, input included.
// Reset clears valid bits and loads the configuration defaults; palette contents stay undefined.
// Depends on ipc_pkg, ipc_ram and ipc_mod_pipe.
module iteration_palette_colorizer_unit #(
  parameter int TABLE_DEPTH   = 4096,
  parameter int HUE_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // entry_address[11:0], hue_value[35:12], iteration_count[59:36], zeros
  input  logic [63:0]                 s_tdata,
  // operation[0]
  input  logic                        s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // red[7:0], green[15:8], blue[23:16]
  output logic [23:0]                 m_tdata,
  input  logic                        cfg_we,
  input  logic [ipc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ipc_pkg::CfgW-1:0]    cfg_data
);
  import ipc_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int NW  = $clog2(TABLE_DEPTH + 1);
  localparam int HFB = HUE_FRAC_BITS;

  logic [12:0]          entries;
  logic [15:0]          scale;
  logic [31:0]          phase;
  logic [HueW-1:0]      offset;
  logic [HueW-1:0]      hmin;
  logic [HueW-1:0]      hmax;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries <= 13'd200;
      scale   <= 16'd256;
      phase   <= '0;
      offset  <= '0;
      hmin    <= '0;
      hmax    <= 24'd3276800;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENTRIES: entries <= cfg_data[12:0];
        REG_SCALE:   scale   <= cfg_data[15:0];
        REG_PHASE:   phase   <= cfg_data;
        REG_OFFSET:  offset  <= cfg_data[HueW-1:0];
        REG_MIN:     hmin    <= cfg_data[HueW-1:0];
        REG_MAX:     hmax    <= cfg_data[HueW-1:0];
        default: ;
      endcase
    end
  end

  logic [NW-1:0] n_eff;
  assign n_eff = (32'(entries) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : NW'(entries);

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic [CountW-1:0] in_count;
  logic [CountW:0]   count_x;
  logic [CountW:0]   n_x;
  logic              in_black;
  assign in_count = s_tdata[59:36];
  assign count_x  = {1'b0, in_count};
  assign n_x      = (CountW + 1)'(n_eff);
  assign in_black = (n_eff == '0) || (count_x >= n_x) || ((count_x + 1'b1) == n_x);

  logic              s1_valid;
  side_t             s1_side;
  logic [SumW-1:0]   s1_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side.op    <= s_tuser;
      s1_side.addr  <= s_tdata[11:0];
      s1_side.hv    <= s_tdata[35:12];
      s1_side.black <= in_black;
      s1_sum        <= {(SumW - CountW)'(0), in_count} + {phase[31], phase};
    end
  end

  logic                    s2_valid;
  side_t                   s2_side;
  logic signed [ProdW-1:0] s2_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side <= s1_side;
      s2_prod <= ProdW'($signed(s1_sum)) * ProdW'($signed({1'b0, scale}));
    end
  end

  logic [ProdW-1:0] abs_prod;
  assign abs_prod = s2_prod[ProdW-1] ? (~s2_prod + 1'b1) : s2_prod;

  logic            s3_valid;
  side_t           s3_side;
  logic            s3_neg;
  logic [QuoW-1:0] s3_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side <= s2_side;
      s3_neg  <= s2_prod[ProdW-1];
      s3_mag  <= abs_prod[ScaleSh+QuoW-1:ScaleSh];
    end
  end

  logic          q_valid;
  side_t         q_side;
  logic [NW-1:0] q_rem;

  ipc_mod_pipe #(
    .DW(QuoW),
    .NW(NW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s3_valid),
    .in_side  (s3_side),
    .in_neg   (s3_neg),
    .in_mag   (s3_mag),
    .n        (n_eff),
    .out_valid(q_valid),
    .out_side (q_side),
    .out_rem  (q_rem)
  );

  logic [AW-1:0]   ram_addr;
  logic            ram_we;
  logic [HueW-1:0] ram_rdata;
  assign ram_addr = (q_side.op == OP_LOAD) ? AW'(q_side.addr) : AW'(q_rem);
  assign ram_we   = en && q_valid && (q_side.op == OP_LOAD) && (32'(q_side.addr) < TABLE_DEPTH);

  ipc_ram #(
    .W(HueW),
    .D(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .re   (en),
    .addr (ram_addr),
    .wdata(q_side.hv),
    .rdata(ram_rdata)
  );

  logic r_valid;
  logic r_black;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (en) begin
      r_valid <= q_valid && (q_side.op == OP_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_black <= q_side.black;
    end
  end

  logic signed [HueW:0] hue_d;
  logic                 out_window;
  logic [HueW-1:0]      hue_mag;
  logic [HFB+2:0]       h6;
  logic [HFB:0]         t6;
  logic [HFB:0]         x_val;
  assign hue_d      = $signed({ram_rdata[HueW-1], ram_rdata})
                    - $signed({offset[HueW-1], offset});
  assign out_window = (hue_d < $signed({hmin[HueW-1], hmin}))
                   || (hue_d > $signed({hmax[HueW-1], hmax}));
  assign hue_mag    = ram_rdata[HueW-1] ? (~ram_rdata + 1'b1) : ram_rdata;
  assign h6         = (HFB + 3)'(hue_mag[HFB-1:0]) * (HFB + 3)'(6);
  assign t6         = h6[HFB:0];
  assign x_val      = t6[HFB] ? ((HFB + 1)'(1) << (HFB + 1)) - t6 : t6;

  logic         a_valid;
  logic         a_black;
  logic [2:0]   a_sector;
  logic [HFB:0] a_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_black  <= r_black || out_window;
      a_sector <= h6[HFB+2:HFB];
      a_x      <= x_val;
    end
  end

  logic [HFB+8:0]   x255;
  logic [ChanW-1:0] xv;
  logic [23:0]      rgb;
  assign x255 = (HFB + 9)'(a_x) * (HFB + 9)'(255);
  assign xv   = x255[HFB+7:HFB];

  always_comb begin
    unique case (a_sector)
      3'd0:    rgb = {8'd0, xv, 8'd255};
      3'd1:    rgb = {8'd0, 8'd255, xv};
      3'd2:    rgb = {xv, 8'd255, 8'd0};
      3'd3:    rgb = {8'd255, xv, 8'd0};
      3'd4:    rgb = {8'd255, 8'd0, xv};
      default: rgb = {xv, 8'd0, 8'd255};
    endcase
    if (a_black) begin
      rgb = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= rgb;
    end
  end

`ifndef ASSERT_OFF
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    q_valid && (q_side.op == OP_PIXEL) && !q_side.black |-> (q_rem < n_eff))
    else $error("palette index not below entry count");

  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_black |-> (a_sector <= 3'd5))
    else $error("hue sector out of range");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid && !q_valid)
    else $error("pipeline valid after reset");
`endif

endmodule
